/* hdl/bqv_pkg.sv */
// ----------------------------------------------------------------------------
// Billboard quad vertex generator package
// Shared request and corner payload types, register map and constants.
// ----------------------------------------------------------------------------
package bqv_pkg;

  localparam int CFG_W = 31;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_BOTTOM_WIDTH = 2'd0,
    REG_TOP_WIDTH    = 2'd1,
    REG_QUAD_HEIGHT  = 2'd2
  } bqv_reg_t;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef struct packed {
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } bqv_in_t;

  typedef struct packed {
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic signed [31:0] corner_z;
    logic [1:0]         corner_index;
    logic               last_corner;
  } bqv_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] bottom_width;
    logic [CFG_W-1:0] top_width;
    logic [CFG_W-1:0] quad_height;
  } bqv_cfg_t;

endpackage

/* hdl/bqv_norm.sv */
// ----------------------------------------------------------------------------
// Vector normalizer
// Pipelined 3-vector normalization: leading-one search, shift into range,
// sum of squares, one square root bit per stage, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bqv_norm #(
  parameter int IW = 33,
  parameter int FRAC_BITS = 16,
  parameter int SW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [2:0][IW-1:0]        vec,
  input  logic [SW-1:0]             side_in,
  output logic                      out_valid,
  output logic [2:0][FRAC_BITS+1:0] unit,
  output logic [SW-1:0]             side_out
);

  localparam int OW = FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int NC = (IW + 7) / 8;
  localparam int CIW = NC * 8;
  localparam int PW = $clog2(CIW);
  localparam int MN_W = 30;
  localparam int XW = CIW + MN_W;
  localparam int SQ_W = 2 * MN_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int LEN_W = ROOT_STEPS;
  localparam int DIV_W = LEN_W + 1;
  localparam int ST_SQ = 1;
  localparam int ST_ROOT = 3;
  localparam int ST_DIV = ST_ROOT + ROOT_STEPS;
  localparam int ST_OUT = ST_DIV + QW;
  localparam int NCY = ST_OUT + 1;

  typedef struct packed {
    logic [SW-1:0]           side;
    logic [2:0]              neg;
    logic                    zero;
    logic [2:0][MN_W-1:0]    mn;
  } carry_t;

  logic                 v1, v2, v3;
  logic [2:0][IW-1:0]   mag1, mag2, mag3;
  logic [2:0]           neg1, neg2, neg3;
  logic [SW-1:0]        side1, side2, side3;
  logic [CIW-1:0]       orv;
  logic [NC-1:0]        cnz_next, cnz2;
  logic [NC-1:0][2:0]   cpos_next, cpos2;
  logic [PW-1:0]        p_next, p3;
  logic                 zero3;
  carry_t               cy_next;
  carry_t               cy [NCY];
  logic [NCY-1:0]       vl;
  logic [2:0][SQ_W-1:0] sq;
  logic [SUM_W-1:0]     rn [ROOT_STEPS+1];
  logic [SUM_W-1:0]     rt [ROOT_STEPS+1];
  logic [2:0][DIV_W-1:0] pr [QW];
  logic [2:0][QW-1:0]   qq [QW];
  logic [LEN_W-1:0]     dd [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vl <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      vl <= {vl[NCY-2:0], v3};
    end
  end

  always_comb begin
    orv = CIW'(mag1[0] | mag1[1] | mag1[2]);
    for (int c = 0; c < NC; c++) begin
      cnz_next[c] = |orv[c*8 +: 8];
      cpos_next[c] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (orv[c*8+b]) cpos_next[c] = 3'(b);
      end
    end
  end

  always_comb begin
    p_next = '0;
    for (int c = 0; c < NC; c++) begin
      if (cnz2[c]) p_next = PW'(c * 8 + int'(cpos2[c]));
    end
  end

  always_comb begin
    logic [XW-1:0] wide;
    cy_next.side = side3;
    cy_next.neg = neg3;
    cy_next.zero = zero3;
    for (int i = 0; i < 3; i++) begin
      wide = XW'(mag3[i]);
      if (int'(p3) >= MN_W - 1) begin
        wide = wide >> (int'(p3) - (MN_W - 1));
      end else begin
        wide = wide << ((MN_W - 1) - int'(p3));
      end
      cy_next.mn[i] = wide[MN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= vec[i][IW-1];
        mag1[i] <= vec[i][IW-1] ? -vec[i] : vec[i];
      end
      side1 <= side_in;
      mag2 <= mag1;
      neg2 <= neg1;
      side2 <= side1;
      cnz2 <= cnz_next;
      cpos2 <= cpos_next;
      mag3 <= mag2;
      neg3 <= neg2;
      side3 <= side2;
      zero3 <= ~|cnz2;
      p3 <= p_next;
      cy[0] <= cy_next;
      for (int s = 1; s < NCY; s++) begin
        cy[s] <= cy[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        sq[i] <= cy[0].mn[i] * cy[0].mn[i];
      end
      rn[0] <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      rt[0] <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [SUM_W-1:0] RBIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W-1:0] trial;
    assign trial = rt[k] + RBIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rn[k] >= trial) begin
          rn[k+1] <= rn[k] - trial;
          rt[k+1] <= (rt[k] >> 1) + RBIT;
        end else begin
          rn[k+1] <= rn[k];
          rt[k+1] <= rt[k] >> 1;
        end
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [2:0][DIV_W-1:0] p_src;
    logic [2:0][QW-1:0]    q_src;
    logic [LEN_W-1:0]      d_src;
    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          p_src[i] = DIV_W'(cy[ST_DIV-1].mn[i]);
        end
        q_src = '0;
        d_src = rt[ROOT_STEPS][LEN_W-1:0];
      end
    end else begin : g_next
      assign p_src = pr[j-1];
      assign q_src = qq[j-1];
      assign d_src = dd[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dd[j] <= d_src;
        for (int i = 0; i < 3; i++) begin
          if (p_src[i] >= DIV_W'(d_src)) begin
            pr[j][i] <= (p_src[i] - DIV_W'(d_src)) << 1;
            qq[j][i] <= q_src[i] | (QW'(1) << B);
          end else begin
            pr[j][i] <= p_src[i] << 1;
            qq[j][i] <= q_src[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [OW-1:0] qx;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qx = OW'(qq[QW-1][i]);
        if (cy[ST_OUT-1].zero) begin
          unit[i] <= '0;
        end else begin
          unit[i] <= cy[ST_OUT-1].neg[i] ? -qx : qx;
        end
      end
    end
  end

  assign out_valid = vl[NCY-1];
  assign side_out = cy[NCY-1].side;

endmodule

/* hdl/bqv_cross.sv */
// ----------------------------------------------------------------------------
// Cross product unit
// Three-stage exact cross product a x b with an optional replacement vector
// when the product is exactly zero.
// ----------------------------------------------------------------------------
module bqv_cross #(
  parameter int AW = 32,
  parameter int BW = 18,
  parameter int SW = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2:0][AW-1:0]       a,
  input  logic [2:0][BW-1:0]       b,
  input  logic [2:0][AW+BW:0]      alt,
  input  logic                     alt_en,
  input  logic [SW-1:0]            side_in,
  output logic                     out_valid,
  output logic [2:0][AW+BW:0]      res,
  output logic [SW-1:0]            side_out
);

  localparam int PRW = AW + BW;
  localparam int RW = PRW + 1;

  logic [2:0]            cv;
  logic [SW-1:0]         sd1, sd2;
  logic [2:0][RW-1:0]    al1, al2;
  logic signed [PRW-1:0] pp0 [3];
  logic signed [PRW-1:0] pp1 [3];
  logic signed [RW-1:0]  df [3];
  logic                  zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= '0;
    end else if (en) begin
      cv <= {cv[1:0], in_valid};
    end
  end

  assign zero = (df[0] == '0) && (df[1] == '0) && (df[2] == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      pp0[0] <= $signed(a[1]) * $signed(b[2]);
      pp1[0] <= $signed(a[2]) * $signed(b[1]);
      pp0[1] <= $signed(a[2]) * $signed(b[0]);
      pp1[1] <= $signed(a[0]) * $signed(b[2]);
      pp0[2] <= $signed(a[0]) * $signed(b[1]);
      pp1[2] <= $signed(a[1]) * $signed(b[0]);
      sd1 <= side_in;
      al1 <= alt;
      for (int i = 0; i < 3; i++) begin
        df[i] <= RW'(pp0[i]) - RW'(pp1[i]);
      end
      sd2 <= sd1;
      al2 <= al1;
      for (int i = 0; i < 3; i++) begin
        res[i] <= (alt_en && zero) ? al2[i] : df[i];
      end
      side_out <= sd2;
    end
  end

  assign out_valid = cv[2];

endmodule

/* hdl/bqv_expand.sv */
// ----------------------------------------------------------------------------
// Corner expander
// Scales the unit axes by the half widths and half height, forms the four
// saturated corners and hands them out one per cycle while the corner port is not stalled.
// ----------------------------------------------------------------------------
module bqv_expand #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [2:0][31:0]          centre,
  input  logic [2:0][FRAC_BITS+1:0] hor,
  input  logic [2:0][FRAC_BITS+1:0] ver,
  input  bqv_pkg::bqv_cfg_t         cfg,
  output logic                      adv,
  output logic                      corner_valid,
  input  logic                      corner_stall,
  output bqv_pkg::bqv_out_t         corner
);

  import bqv_pkg::*;

  localparam int UW = FRAC_BITS + 2;
  localparam int MW = UW - 1;
  localparam int PRODW = MW + CFG_W;
  localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

  logic [CFG_W-1:0]       wb, wt, wh;
  logic [2:0][MW-1:0]     hmag, vmag;
  logic                   e1_valid;
  logic [2:0][31:0]       cen1;
  logic [2:0]             hneg1, vneg1;
  logic [2:0][PRODW-1:0]  pb, pt, pv;
  logic [31:0]            cs [4][3];
  logic [1:0]             idx;

  function automatic logic [31:0] sat32(input logic signed [33:0] x);
    if (x[33:31] != 3'b000 && x[33:31] != 3'b111) begin
      return x[33] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [33:0] signed_half(input logic [PRODW-1:0] p,
                                                     input logic neg);
    logic signed [33:0] m;
    m = 34'(p[PRODW-1:MW]);
    return neg ? -m : m;
  endfunction

  always_comb begin
    wb = cfg.bottom_width;
    wt = cfg.top_width;
    wh = cfg.quad_height;
    if (wh == '0) wh = ONE;
    if (wb == '0 && wt == '0) begin
      wb = ONE;
      wt = ONE;
    end
    for (int i = 0; i < 3; i++) begin
      hmag[i] = MW'(hor[i][UW-1] ? -hor[i] : hor[i]);
      vmag[i] = MW'(ver[i][UW-1] ? -ver[i] : ver[i]);
    end
  end

  assign adv = !corner_valid || (!corner_stall && idx == CORNER_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else if (adv) begin
      e1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [33:0] pe, hb, ht, vv;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pb[i] <= hmag[i] * wb;
        pt[i] <= hmag[i] * wt;
        pv[i] <= vmag[i] * wh;
        hneg1[i] <= hor[i][UW-1];
        vneg1[i] <= ver[i][UW-1];
      end
      cen1 <= centre;
      for (int i = 0; i < 3; i++) begin
        pe = 34'($signed(cen1[i]));
        hb = signed_half(pb[i], hneg1[i]);
        ht = signed_half(pt[i], hneg1[i]);
        vv = signed_half(pv[i], vneg1[i]);
        cs[0][i] <= sat32(pe + hb + vv);
        cs[1][i] <= sat32(pe - hb + vv);
        cs[2][i] <= sat32(pe + ht - vv);
        cs[3][i] <= sat32(pe - ht - vv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_valid <= 1'b0;
      idx <= '0;
    end else if (adv) begin
      corner_valid <= e1_valid;
      idx <= '0;
    end else if (!corner_stall) begin
      idx <= idx + 2'd1;
    end
  end

  always_comb begin
    corner.corner_x = cs[idx][0];
    corner.corner_y = cs[idx][1];
    corner.corner_z = cs[idx][2];
    corner.corner_index = idx;
    corner.last_corner = (idx == CORNER_LAST);
  end

endmodule

/* hdl/billboard_quad_vertex_generator_unit.sv */
// ----------------------------------------------------------------------------
// Billboard quad vertex generator
// Expands one billboard centre and camera into four camera-facing corners.
// ----------------------------------------------------------------------------
// A billboard request can be accepted in every cycle while the pipeline has
// room, but each request yields four corners on a result port that carries
// one corner per cycle, so while a quad's corners are shown the pipeline
// advances only as its last corner leaves. Most of the path from acceptance
// to the first corner lies in the three normalizers, each with one square
// root bit and one quotient bit per pipeline stage. A stall on the corner
// port freezes the whole pipeline.
module billboard_quad_vertex_generator_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          billboard_valid,
  output logic                          billboard_stall,
  input  bqv_pkg::bqv_in_t              billboard,
  output logic                          corner_valid,
  input  logic                          corner_stall,
  output bqv_pkg::bqv_out_t             corner,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bqv_pkg::PADDR_W-1:0]   paddr,
  input  logic [bqv_pkg::PDATA_W-1:0]   pwdata,
  output logic [bqv_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  import bqv_pkg::*;

  localparam int UW = FRAC_BITS + 2;
  localparam int RW1 = 32 + UW + 1;
  localparam int RW2 = 2 * UW + 1;
  localparam int SW1 = 192;
  localparam int SW2 = 96 + 3 * UW;
  localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

  bqv_cfg_t             cfg;
  logic                 adv;
  logic                 s0_valid;
  logic [2:0][31:0]     s0_centre, s0_up;
  logic [2:0][32:0]     s0_view;

  logic                 n1_valid;
  logic [2:0][UW-1:0]   n1_unit;
  logic [SW1-1:0]       n1_side;
  logic [2:0][31:0]     n1_up;
  logic [2:0][RW1-1:0]  alt1;

  logic                 c1_valid;
  logic [2:0][RW1-1:0]  c1_res;
  logic [SW2-1:0]       c1_side;

  logic                 n2_valid;
  logic [2:0][UW-1:0]   n2_unit;
  logic [SW2-1:0]       n2_side;

  logic                 c2_valid;
  logic [2:0][RW2-1:0]  c2_res;
  logic [SW2-1:0]       c2_side;

  logic                 n3_valid;
  logic [2:0][UW-1:0]   n3_unit;
  logic [SW2-1:0]       n3_side;
  logic [2:0][31:0]     n3_centre;
  logic [2:0][UW-1:0]   n3_hor;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bottom_width <= ONE;
      cfg.top_width <= ONE;
      cfg.quad_height <= ONE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[PADDR_W-1:2])
        REG_BOTTOM_WIDTH: cfg.bottom_width <= pwdata[CFG_W-1:0];
        REG_TOP_WIDTH:    cfg.top_width <= pwdata[CFG_W-1:0];
        REG_QUAD_HEIGHT:  cfg.quad_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_BOTTOM_WIDTH: prdata = PDATA_W'(cfg.bottom_width);
      REG_TOP_WIDTH:    prdata = PDATA_W'(cfg.top_width);
      REG_QUAD_HEIGHT:  prdata = PDATA_W'(cfg.quad_height);
      default:          prdata = '0;
    endcase
  end

  assign billboard_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= billboard_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_centre[0] <= billboard.centre_x;
      s0_centre[1] <= billboard.centre_y;
      s0_centre[2] <= billboard.centre_z;
      s0_up[0] <= billboard.up_x;
      s0_up[1] <= billboard.up_y;
      s0_up[2] <= billboard.up_z;
      s0_view[0] <= 33'(billboard.look_x) - 33'(billboard.eye_x);
      s0_view[1] <= 33'(billboard.look_y) - 33'(billboard.eye_y);
      s0_view[2] <= 33'(billboard.look_z) - 33'(billboard.eye_z);
    end
  end

  bqv_norm #(.IW(33), .FRAC_BITS(FRAC_BITS), .SW(SW1)) u_norm_view (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(s0_valid), .vec(s0_view), .side_in({s0_centre, s0_up}),
    .out_valid(n1_valid), .unit(n1_unit), .side_out(n1_side)
  );

  assign n1_up = n1_side[95:0];

  always_comb begin
    alt1[0] = RW1'($signed(n1_up[1]));
    alt1[1] = RW1'($signed(n1_up[0]));
    alt1[2] = RW1'($signed(n1_up[2]));
  end

  bqv_cross #(.AW(32), .BW(UW), .SW(SW2)) u_cross_hor (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(n1_valid), .a(n1_up), .b(n1_unit), .alt(alt1), .alt_en(1'b1),
    .side_in({n1_side[SW1-1:96], n1_unit}),
    .out_valid(c1_valid), .res(c1_res), .side_out(c1_side)
  );

  bqv_norm #(.IW(RW1), .FRAC_BITS(FRAC_BITS), .SW(SW2)) u_norm_hor (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(c1_valid), .vec(c1_res), .side_in(c1_side),
    .out_valid(n2_valid), .unit(n2_unit), .side_out(n2_side)
  );

  bqv_cross #(.AW(UW), .BW(UW), .SW(SW2)) u_cross_ver (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(n2_valid), .a(n2_unit), .b(n2_side[3*UW-1:0]), .alt('0),
    .alt_en(1'b0), .side_in({n2_side[SW2-1:3*UW], n2_unit}),
    .out_valid(c2_valid), .res(c2_res), .side_out(c2_side)
  );

  bqv_norm #(.IW(RW2), .FRAC_BITS(FRAC_BITS), .SW(SW2)) u_norm_ver (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(c2_valid), .vec(c2_res), .side_in(c2_side),
    .out_valid(n3_valid), .unit(n3_unit), .side_out(n3_side)
  );

  assign n3_centre = n3_side[SW2-1:3*UW];
  assign n3_hor = n3_side[3*UW-1:0];

  bqv_expand #(.FRAC_BITS(FRAC_BITS)) u_expand (
    .clk(clk), .rst(rst),
    .in_valid(n3_valid), .centre(n3_centre), .hor(n3_hor), .ver(n3_unit),
    .cfg(cfg), .adv(adv),
    .corner_valid(corner_valid), .corner_stall(corner_stall), .corner(corner)
  );

endmodule

/* hdl/bqv_checker.sv */
// ----------------------------------------------------------------------------
// Billboard quad vertex generator port checker
// Watches the result port for corner ordering, the last-corner flag, stall and reset behavior.
// ----------------------------------------------------------------------------
module bqv_port_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          billboard_valid,
  input logic                          billboard_stall,
  input bqv_pkg::bqv_in_t              billboard,
  input logic                          corner_valid,
  input logic                          corner_stall,
  input bqv_pkg::bqv_out_t             corner,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [bqv_pkg::PADDR_W-1:0]   paddr,
  input logic [bqv_pkg::PDATA_W-1:0]   pwdata,
  input logic [bqv_pkg::PDATA_W-1:0]   prdata,
  input logic                          pready
);

  import bqv_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    corner_valid && corner_stall |=> corner_valid && $stable(corner))
    else $error("corner changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    corner_valid && !corner_stall && !corner.last_corner |=>
      corner_valid && corner.corner_index == $past(corner.corner_index) + 2'd1)
    else $error("corner sequence broken");

  a_last: assert property (@(posedge clk) disable iff (rst)
    corner_valid |-> corner.last_corner == (corner.corner_index == CORNER_LAST))
    else $error("last corner flag mismatch");

  a_reset: assert property (@(posedge clk)
    rst |=> !corner_valid)
    else $error("corner shown after reset");

endmodule

bind billboard_quad_vertex_generator_unit bqv_port_checker u_bqv_checker (.*);

/* tb/bqv_checker.sv */
// ----------------------------------------------------------------------------
// Billboard corner checker
// Watches the request and corner channels and the register port, predicts the
// four corners of every accepted billboard and compares them in order.
// ----------------------------------------------------------------------------
module bqv_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         billboard_valid,
  input  logic                         billboard_stall,
  input  bqv_pkg::bqv_in_t             billboard,
  input  logic                         corner_valid,
  input  logic                         corner_stall,
  input  bqv_pkg::bqv_out_t            corner,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [bqv_pkg::PADDR_W-1:0]  paddr,
  input  logic [bqv_pkg::PDATA_W-1:0]  pwdata,
  output int                           errors,
  output int                           pending
);
  import bqv_pkg::*;

  localparam int FB = 16;

  logic [30:0] bottom_w, top_w, height_w;
  bqv_out_t corners_due [$];

  assign pending = corners_due.size();

  function automatic longint unsigned abs64(longint c);
    return c < 0 ? -c : c;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic void unit_vec(ref longint v [3]);
    longint unsigned m [3];
    longint unsigned mx, sum, len, r;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return;
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      r = (m[i] << FB) / len;
      v[i] = v[i] < 0 ? -longint'(r) : longint'(r);
    end
  endfunction

  function automatic void cross_prod(input longint a [3], input longint b [3],
                                     ref longint r [3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint half_of(longint u, longint unsigned w);
    longint s;
    s = longint'((abs64(u) * w) >> (FB + 1));
    return u < 0 ? -s : s;
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x[31:0];
  endfunction

  task automatic predict_quad(input bqv_in_t b);
    longint pos [3], upv [3], view [3], hor [3], ver [3];
    longint unsigned wb, wt, hl;
    longint h, hs, vs;
    bqv_out_t c;
    pos[0] = b.centre_x; pos[1] = b.centre_y; pos[2] = b.centre_z;
    upv[0] = b.up_x; upv[1] = b.up_y; upv[2] = b.up_z;
    view[0] = longint'(b.look_x) - longint'(b.eye_x);
    view[1] = longint'(b.look_y) - longint'(b.eye_y);
    view[2] = longint'(b.look_z) - longint'(b.eye_z);
    wb = bottom_w;
    wt = top_w;
    hl = height_w;
    if (hl == 0) hl = 64'd1 << FB;
    if (wb == 0 && wt == 0) begin
      wb = 64'd1 << FB;
      wt = 64'd1 << FB;
    end
    unit_vec(view);
    cross_prod(upv, view, hor);
    if (hor[0] == 0 && hor[1] == 0 && hor[2] == 0) begin
      hor[0] = upv[1];
      hor[1] = upv[0];
      hor[2] = upv[2];
    end
    unit_vec(hor);
    cross_prod(hor, view, ver);
    unit_vec(ver);
    for (int k = 0; k < 4; k++) begin
      hs = (k & 1) ? -1 : 1;
      vs = (k < 2) ? 1 : -1;
      h = half_of(hor[0], k < 2 ? wb : wt);
      c.corner_x = clamp32(pos[0] + hs * h + vs * half_of(ver[0], hl));
      h = half_of(hor[1], k < 2 ? wb : wt);
      c.corner_y = clamp32(pos[1] + hs * h + vs * half_of(ver[1], hl));
      h = half_of(hor[2], k < 2 ? wb : wt);
      c.corner_z = clamp32(pos[2] + hs * h + vs * half_of(ver[2], hl));
      c.corner_index = 2'(k);
      c.last_corner = (k == CORNER_LAST);
      corners_due.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    bqv_out_t e;
    int bad;
    bad = 0;
    if (rst) begin
      bottom_w <= 31'd1 << FB;
      top_w <= 31'd1 << FB;
      height_w <= 31'd1 << FB;
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (bqv_reg_t'(paddr[3:2]))
          REG_BOTTOM_WIDTH: bottom_w <= pwdata[30:0];
          REG_TOP_WIDTH:    top_w <= pwdata[30:0];
          REG_QUAD_HEIGHT:  height_w <= pwdata[30:0];
          default: ;
        endcase
      end
      if (billboard_valid && !billboard_stall) predict_quad(billboard);
      if (corner_valid && !corner_stall) begin
        if (corners_due.size() == 0) begin
          $error("unexpected corner %p", corner);
          bad++;
        end else begin
          e = corners_due.pop_front();
          if (e.corner_x !== corner.corner_x) begin
            $error("corner_x expected %0d got %0d", e.corner_x, corner.corner_x);
            bad++;
          end
          if (e.corner_y !== corner.corner_y) begin
            $error("corner_y expected %0d got %0d", e.corner_y, corner.corner_y);
            bad++;
          end
          if (e.corner_z !== corner.corner_z) begin
            $error("corner_z expected %0d got %0d", e.corner_z, corner.corner_z);
            bad++;
          end
          if (e.corner_index !== corner.corner_index) begin
            $error("corner_index expected %0d got %0d", e.corner_index,
                   corner.corner_index);
            bad++;
          end
          if (e.last_corner !== corner.last_corner) begin
            $error("last_corner expected %0d got %0d", e.last_corner,
                   corner.last_corner);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Billboard quad vertex generator testbench
// Drives directed and random billboard requests under five register settings
// and three idling patterns; the checker predicts and compares every corner.
// ----------------------------------------------------------------------------
module tb;
  import bqv_pkg::*;

  logic clk, rst;
  logic billboard_valid, billboard_stall;
  bqv_in_t billboard;
  logic corner_valid, corner_stall;
  bqv_out_t corner;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  int errors, pending;
  int send_idle, recv_idle;

  billboard_quad_vertex_generator_unit uut (.*);

  bqv_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) corner_stall <= 1'b0;
    else corner_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic reg_write(input bqv_reg_t r, input logic [31:0] d);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= PADDR_W'(r) << 2;
    pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 0;
      3: return $urandom_range(200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input bqv_in_t b);
    while ($urandom_range(99) < send_idle) begin
      billboard_valid <= 0;
      @(posedge clk);
    end
    billboard <= b;
    billboard_valid <= 1;
    @(posedge clk);
    while (billboard_stall) @(posedge clk);
  endtask

  task automatic drain();
    billboard_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic random_billboards(input int n);
    bqv_in_t b;
    for (int i = 0; i < n; i++) begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(3) != 0) begin
        b.centre_x = rand_word(); b.centre_y = rand_word();
        b.eye_x = rand_word(); b.look_x = rand_word();
        b.up_y = rand_word(); b.up_z = rand_word();
      end
      if ($urandom_range(9) == 0) begin
        b.up_x = 0; b.up_z = 0;
        b.look_x = b.eye_x; b.look_z = b.eye_z;
      end
      if ($urandom_range(9) == 0) begin
        b.look_x = b.eye_x; b.look_y = b.eye_y; b.look_z = b.eye_z;
      end
      send(b);
    end
  endtask

  initial begin
    bqv_in_t b;
    rst = 1;
    billboard_valid = 0;
    billboard = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    send_idle = 15; recv_idle = 60;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    b = '0;
    b.look_z = 32'h10000; b.up_y = 32'h10000;
    send(b);
    b.up_y = 0; b.up_z = 32'h10000;
    send(b);
    b = '0;
    b.up_y = 32'h10000;
    send(b);
    send('0);
    b = {12{32'h7fffffff}};
    b.eye_x = 32'h80000000;
    send(b);
    b = {12{32'h80000000}};
    b.look_y = 32'h7fffffff;
    send(b);
    b = {12{32'hffffffff}};
    b.look_z = 32'h10000;
    send(b);
    drain();

    reg_write(REG_BOTTOM_WIDTH, 0);
    reg_write(REG_TOP_WIDTH, 0);
    reg_write(REG_QUAD_HEIGHT, 0);
    b = '0;
    b.centre_x = 32'h7fff0000; b.look_x = 32'h10000; b.up_y = 32'h10000;
    send(b);
    drain();
    reg_write(REG_TOP_WIDTH, 32'h20000);
    send(b);
    drain();
    random_billboards(30);
    drain();

    send_idle = 60; recv_idle = 15;
    reg_write(REG_BOTTOM_WIDTH, 32'h7fffffff);
    reg_write(REG_TOP_WIDTH, 32'hffffffff);
    reg_write(REG_QUAD_HEIGHT, 32'h7fffffff);
    random_billboards(40);
    drain();

    send_idle = 0; recv_idle = 0;
    reg_write(REG_BOTTOM_WIDTH, $urandom);
    reg_write(REG_TOP_WIDTH, $urandom);
    reg_write(REG_QUAD_HEIGHT, $urandom);
    random_billboards(40);
    drain();

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
